/* rtl/rtk_pkg.sv */
// Shared types for the route top-k selector: request and result payloads,
// the per-cell slot and control types, and the controller state enum.
// No dependencies.
package rtk_pkg;

    localparam logic [2:0] RSTATE_BROKEN      = 3'd3;
    localparam logic [2:0] RSTATE_DISCOVERING = 3'd4;

    typedef struct packed {
        logic        present;
        logic [31:0] route_dest;
        logic [7:0]  metric;
        logic [7:0]  route_hops;
        logic [2:0]  route_state;
        logic        last_entry;
    } rtk_in_t;

    typedef struct packed {
        logic        empty_res;
        logic [31:0] ad_dest;
        logic [7:0]  ad_metric;
        logic [7:0]  ad_hops;
        logic [3:0]  ad_total;
        logic        last_ad;
    } rtk_out_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] dest;
        logic [7:0]  metric;
        logic [7:0]  hops;
    } slot_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        slot_t    ins;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } rtk_state_t;

endpackage

/* rtl/rtk_cell.sv */
// One slot of the sorted chain: compares the broadcast entry against its own,
// shifts right on insertion and left on readout.
// Depends on rtk_pkg.
module rtk_cell
    import rtk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  slot_t      left_slot,
    input  logic       left_moves,
    input  slot_t      right_slot,
    output slot_t      slot,
    output logic       moves
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] dest_reg;
    logic [31:0] dest_next;
    logic [7:0]  metric_reg;
    logic [7:0]  metric_next;
    logic [7:0]  hops_reg;
    logic [7:0]  hops_next;

    // The slot gives way when it is empty or holds a strictly worse metric,
    // so that equal metrics stay in arrival order.
    assign moves = !valid_reg || (metric_reg > ctrl.ins.metric);

    assign slot.valid  = valid_reg;
    assign slot.dest   = dest_reg;
    assign slot.metric = metric_reg;
    assign slot.hops   = hops_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        dest_next   = dest_reg;
        metric_next = metric_reg;
        hops_next   = hops_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (moves)
                begin
                    if (!left_moves)
                    begin
                        valid_next  = ctrl.ins.valid;
                        dest_next   = ctrl.ins.dest;
                        metric_next = ctrl.ins.metric;
                        hops_next   = ctrl.ins.hops;
                    end
                    else
                    begin
                        valid_next  = left_slot.valid;
                        dest_next   = left_slot.dest;
                        metric_next = left_slot.metric;
                        hops_next   = left_slot.hops;
                    end
                end
            end
            CELL_POP:
            begin
                valid_next  = right_slot.valid;
                dest_next   = right_slot.dest;
                metric_next = right_slot.metric;
                hops_next   = right_slot.hops;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg   <= dest_next;
        metric_reg <= metric_next;
        hops_reg   <= hops_next;
    end

endmodule

/* rtl/route_top_k_selector.sv */
// Top level of the route top-k selector: controller, counters, output
// register and the chain of sorting cells.
// Depends on rtk_pkg and rtk_cell.

// Routing table entries are taken one per cycle while busy is low; each
// eligible entry is placed into a row of MAX_ADS compare-and-shift cells in
// the cycle it arrives, so the list is always sorted by metric, ties in
// arrival order. The item marked last_entry starts readout: busy stays high
// while the chain shifts one entry a cycle to the result register, or sends a
// single empty result when the run kept no route, and each result appears on
// res for one cycle with res_valid high.
// The receiver cannot stall; results must be taken as they come.
module route_top_k_selector
    import rtk_pkg::*;
#(
    parameter int MAX_ADS   = 8,
    parameter int MAX_TABLE = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  rtk_in_t  req,
    output logic     res_valid,
    output rtk_out_t res
);

    localparam int CNT_W  = $clog2(MAX_ADS + 1);
    localparam int SEEN_W = $clog2(MAX_TABLE + 1);

    rtk_state_t        state_reg;
    rtk_state_t        state_next;
    logic [CNT_W-1:0]  kept_reg;
    logic [CNT_W-1:0]  kept_next;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  total_next;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    rtk_out_t          res_reg;
    rtk_out_t          res_next;

    cell_ctrl_t        ctrl;
    slot_t             cell_slot [MAX_ADS];
    logic              cell_moves [MAX_ADS];
    logic              accept;
    logic              eligible;
    logic              do_insert;
    logic [CNT_W+3:0]  total_ext;

    assign accept   = start && !busy;
    assign eligible = (req.route_state != RSTATE_BROKEN)
                   && (req.route_state != RSTATE_DISCOVERING);
    assign do_insert = accept && req.present && (seen_reg < SEEN_W'(MAX_TABLE))
                    && eligible;
    assign total_ext = {4'b0000, total_reg};

    assign busy      = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        kept_next      = kept_reg;
        total_next     = total_reg;
        seen_next      = seen_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        ctrl.op        = CELL_HOLD;
        ctrl.ins.valid  = 1'b1;
        ctrl.ins.dest   = req.route_dest;
        ctrl.ins.metric = req.metric;
        ctrl.ins.hops   = req.route_hops;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.present && (seen_reg < SEEN_W'(MAX_TABLE)))
                    begin
                        seen_next = seen_reg + SEEN_W'(1);
                    end
                    if (do_insert)
                    begin
                        ctrl.op = CELL_INSERT;
                        if (kept_reg < CNT_W'(MAX_ADS))
                        begin
                            kept_next = kept_reg + CNT_W'(1);
                        end
                    end
                    if (req.last_entry)
                    begin
                        total_next = kept_next;
                        seen_next  = '0;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                res_valid_next = 1'b1;
                if (kept_reg == '0)
                begin
                    res_next   = '0;
                    res_next.empty_res = 1'b1;
                    res_next.last_ad   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctrl.op               = CELL_POP;
                    res_next.empty_res    = 1'b0;
                    res_next.ad_dest      = cell_slot[0].dest;
                    res_next.ad_metric    = cell_slot[0].metric;
                    res_next.ad_hops      = cell_slot[0].hops;
                    res_next.ad_total     = total_ext[3:0];
                    res_next.last_ad      = (kept_reg == CNT_W'(1));
                    kept_next             = kept_reg - CNT_W'(1);
                    if (kept_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kept_reg      <= '0;
            total_reg     <= '0;
            seen_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kept_reg      <= kept_next;
            total_reg     <= total_next;
            seen_reg      <= seen_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    genvar i;
    generate
        for (i = 0; i < MAX_ADS; i++)
        begin : g_cell
            slot_t left_slot;
            logic  left_moves;
            slot_t right_slot;

            if (i == 0)
            begin : g_head
                assign left_slot  = '0;
                assign left_moves = 1'b0;
            end
            else
            begin : g_body
                assign left_slot  = cell_slot[i-1];
                assign left_moves = cell_moves[i-1];
            end

            if (i == MAX_ADS - 1)
            begin : g_tail
                assign right_slot = '0;
            end
            else
            begin : g_inner
                assign right_slot = cell_slot[i+1];
            end

            rtk_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .left_slot  (left_slot),
                .left_moves (left_moves),
                .right_slot (right_slot),
                .slot       (cell_slot[i]),
                .moves      (cell_moves[i])
            );
        end
    endgenerate

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for route_top_k_selector: drives routing tables as
// requests, predicts the sorted advertisements and checks every result.
// Depends on rtk_pkg and the route_top_k_selector RTL.
module tb
    import rtk_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ADS     = 8;
    localparam int MAX_TABLE   = 32;
    localparam int ITEM_TARGET = 480;
    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET_FROM  = 150;
    localparam int QUIET_TO    = 250;

    typedef struct {
        logic [31:0] dest;
        logic [7:0]  metric;
        logic [7:0]  hops;
    } ranked_route_t;

    typedef struct {
        rtk_in_t req;
        bit      drain_first;
    } pending_req_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    rtk_in_t  req = '0;
    logic     res_valid;
    rtk_out_t res;

    pending_req_t  pending_reqs[$];
    rtk_out_t      adverts_due[$];
    ranked_route_t best_routes[MAX_ADS];
    int            best_cnt = 0;
    int            table_seen = 0;
    int            accepted_cnt = 0;
    int            total_reqs = 0;
    int            mismatches = 0;
    int            cycles = 0;

    route_top_k_selector #(
        .MAX_ADS   (MAX_ADS),
        .MAX_TABLE (MAX_TABLE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .res_valid (res_valid),
        .res       (res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Inserts one accepted request into the ranked list and, on the last
    // entry of a table, queues the advertisements it releases.
    function automatic void rank_route(input rtk_in_t r);
        int       pos;
        int       i;
        rtk_out_t ad;
        if (r.present && table_seen < MAX_TABLE)
        begin
            table_seen++;
            if (r.route_state != RSTATE_BROKEN && r.route_state != RSTATE_DISCOVERING)
            begin
                pos = 0;
                while (pos < best_cnt && best_routes[pos].metric <= r.metric)
                    pos++;
                if (pos < MAX_ADS)
                begin
                    i = (best_cnt < MAX_ADS) ? best_cnt : MAX_ADS - 1;
                    while (i > pos)
                    begin
                        best_routes[i] = best_routes[i - 1];
                        i--;
                    end
                    best_routes[pos] = '{r.route_dest, r.metric, r.route_hops};
                    if (best_cnt < MAX_ADS)
                        best_cnt++;
                end
            end
        end
        if (r.last_entry)
        begin
            if (best_cnt == 0)
            begin
                ad = '0;
                ad.empty_res = 1'b1;
                ad.last_ad = 1'b1;
                adverts_due.push_back(ad);
            end
            else
            begin
                for (i = 0; i < best_cnt; i++)
                begin
                    ad = '0;
                    ad.ad_dest = best_routes[i].dest;
                    ad.ad_metric = best_routes[i].metric;
                    ad.ad_hops = best_routes[i].hops;
                    ad.ad_total = 4'(best_cnt);
                    ad.last_ad = (i == best_cnt - 1);
                    adverts_due.push_back(ad);
                end
            end
            best_cnt = 0;
            table_seen = 0;
        end
    endfunction

    task automatic queue_request(input bit present, input logic [31:0] dest,
                                 input logic [7:0] metric, input logic [7:0] hops,
                                 input logic [2:0] rstate, input bit last,
                                 input bit drain_first);
        pending_req_t p;
        p.req.present = present;
        p.req.route_dest = dest;
        p.req.metric = metric;
        p.req.route_hops = hops;
        p.req.route_state = rstate;
        p.req.last_entry = last;
        p.drain_first = drain_first;
        pending_reqs.push_back(p);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Driver: the request on the bus is taken at an edge with start high and
    // busy low; a new one is offered only once the slot is free.
    always @(posedge clk)
    begin
        bit launch;
        launch = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                rank_route(req);
                accepted_cnt++;
            end
            if (!start || !busy)
            begin
                if (pending_reqs.size() > 0)
                begin
                    launch = (accepted_cnt >= QUIET_FROM && accepted_cnt < QUIET_TO) ||
                             ($urandom_range(0, 99) >= 27);
                    if (pending_reqs[0].drain_first && adverts_due.size() != 0)
                        launch = 1'b0;
                end
                if (launch)
                begin
                    start <= 1'b1;
                    req <= pending_reqs.pop_front().req;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: results are stable through the cycle, so they are sampled on
    // the falling edge, away from the driver's edge.
    always @(negedge clk)
    begin
        rtk_out_t want;
        if (rst_n && res_valid === 1'b1)
        begin
            if (adverts_due.size() == 0)
            begin
                $error("unexpected result: %p", res);
                mismatches++;
            end
            else
            begin
                want = adverts_due.pop_front();
                check_field("empty_res", want.empty_res, res.empty_res);
                check_field("ad_dest", want.ad_dest, res.ad_dest);
                check_field("ad_metric", want.ad_metric, res.ad_metric);
                check_field("ad_hops", want.ad_hops, res.ad_hops);
                check_field("ad_total", want.ad_total, res.ad_total);
                check_field("last_ad", want.last_ad, res.last_ad);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int       len;
        int       k;
        bit       present;
        logic [2:0] rstate;
        logic [7:0] metric;

        // Empty table: only an absent entry carrying the last mark.
        queue_request(1'b0, $urandom, 8'd0, 8'd0, 3'd0, 1'b1, 1'b0);

        // Field extremes, every route state, ties and absent entries.
        queue_request(1'b1, 32'hFFFF_FFFF, 8'd255, 8'd255, 3'd0, 1'b0, 1'b0);
        queue_request(1'b1, 32'h0000_0000, 8'd0, 8'd0, 3'd1, 1'b0, 1'b0);
        queue_request(1'b1, 32'h1234_5678, 8'd100, 8'd7, 3'd2, 1'b0, 1'b0);
        queue_request(1'b1, 32'hDEAD_BEEF, 8'd50, 8'd3, RSTATE_BROKEN, 1'b0, 1'b0);
        queue_request(1'b1, 32'hCAFE_0001, 8'd10, 8'd4, RSTATE_DISCOVERING, 1'b0, 1'b0);
        queue_request(1'b1, 32'h0000_00A5, 8'd100, 8'd9, 3'd5, 1'b0, 1'b0);
        queue_request(1'b1, 32'h0000_00A6, 8'd100, 8'd1, 3'd6, 1'b0, 1'b0);
        queue_request(1'b1, 32'h0000_00A7, 8'd0, 8'd2, 3'd7, 1'b0, 1'b0);
        queue_request(1'b0, $urandom, 8'd1, 8'd1, 3'd0, 1'b0, 1'b0);
        queue_request(1'b0, $urandom, 8'd2, 8'd2, 3'd0, 1'b1, 1'b0);

        // Only skipped states, after the sender has waited for all results.
        queue_request(1'b1, $urandom, 8'd5, 8'd5, RSTATE_BROKEN, 1'b0, 1'b1);
        queue_request(1'b1, $urandom, 8'd6, 8'd6, RSTATE_DISCOVERING, 1'b1, 1'b0);

        // Full list: an equal-to-worst entry is dropped, a better one evicts.
        for (k = 1; k <= MAX_ADS; k++)
            queue_request(1'b1, $urandom, 8'(10 * k), 8'(k), 3'd0, 1'b0, 1'b0);
        queue_request(1'b1, 32'h5555_AAAA, 8'(10 * MAX_ADS), 8'd99, 3'd0, 1'b0, 1'b0);
        queue_request(1'b1, 32'hAAAA_5555, 8'd5, 8'd77, 3'd2, 1'b1, 1'b0);

        // Random tables: mostly short, some past the table limit.
        while (pending_reqs.size() < ITEM_TARGET)
        begin
            if ($urandom_range(0, 11) == 0)
                len = $urandom_range(MAX_TABLE + 1, MAX_TABLE + 8);
            else
                len = $urandom_range(1, 12);
            for (k = 0; k < len; k++)
            begin
                present = ($urandom_range(0, 9) != 0);
                if ($urandom_range(0, 3) == 0)
                    rstate = 3'($urandom_range(3, 7));
                else
                    rstate = 3'($urandom_range(0, 2));
                if ($urandom_range(0, 1) == 0)
                    metric = 8'($urandom_range(0, 15));
                else
                    metric = 8'($urandom_range(0, 255));
                queue_request(present, $urandom, metric, 8'($urandom_range(0, 255)),
                              rstate, k == len - 1,
                              k == 0 && $urandom_range(0, 7) == 0);
            end
        end
        total_reqs = pending_reqs.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted_cnt == total_reqs);
        wait (adverts_due.size() == 0);
        repeat (2 * MAX_ADS + 4) @(posedge clk);
        if (mismatches == 0 && adverts_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* route_top_k_selector.f */
rtl/rtk_pkg.sv
rtl/rtk_cell.sv
rtl/route_top_k_selector.sv
tb/sv/tb.sv
